[rtl/core/led_effect_duty_generator_top_macros.svh]
// Assertion macros shared by the LED effect duty generator.
`ifndef LED_EFFECT_DUTY_GENERATOR_TOP_MACROS_SVH
`define LED_EFFECT_DUTY_GENERATOR_TOP_MACROS_SVH

// Checks a property at every clock edge outside reset.
`define LED_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition in one cycle is followed by a result in the next.
`define LED_ASSERT_NEXT(label, cond, res, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (res)) \
    else $error(msg);

`endif

[rtl/core/led_duty_pkg.sv]
// Types, constants and helper functions for the LED effect duty generator.
package led_duty_pkg;

  localparam int TIME_BITS = 32;
  localparam int CNT_W     = $clog2(TIME_BITS);
  localparam int PHASE_W   = 17;
  localparam int ADDR_W    = 5;

  localparam logic [2:0] MODE_OFF   = 3'd0;
  localparam logic [2:0] MODE_ON    = 3'd1;
  localparam logic [2:0] MODE_BLINK = 3'd2;
  localparam logic [2:0] MODE_GLOW  = 3'd3;
  localparam logic [2:0] MODE_PULSE = 3'd4;

  localparam logic [7:0] FULL_DUTY  = 8'd255;
  localparam logic [7:0] PULSE_DUTY = 8'd50;

  localparam logic [2:0] REG_BLINK_PERIOD  = 3'd0;
  localparam logic [2:0] REG_BLINK_ON_TIME = 3'd1;
  localparam logic [2:0] REG_GLOW_PERIOD   = 3'd2;
  localparam logic [2:0] REG_GLOW_RISE_END = 3'd3;
  localparam logic [2:0] REG_GLOW_FALL_END = 3'd4;
  localparam logic [2:0] REG_PULSE_LENGTH  = 3'd5;

  localparam logic [15:0] BLINK_PERIOD_RST  = 16'd1000;
  localparam logic [15:0] BLINK_ON_TIME_RST = 16'd500;
  localparam logic [15:0] GLOW_PERIOD_RST   = 16'd2048;
  localparam logic [15:0] GLOW_RISE_END_RST = 16'd1024;
  localparam logic [15:0] GLOW_FALL_END_RST = 16'd2048;
  localparam logic [31:0] PULSE_LENGTH_RST  = 32'd100;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DONE
  } state_e;

  // A period of zero behaves as 65536.
  function automatic logic [PHASE_W-1:0] eff_period(input logic [15:0] period);
    eff_period = (period == 16'd0) ? {1'b1, 16'd0} : {1'b0, period};
  endfunction

  // Quarter of a ramp value, clipped to full brightness.
  function automatic logic [7:0] ramp_sat(input logic [PHASE_W-1:0] v);
    logic [PHASE_W-3:0] q;
    q = v[PHASE_W-1:2];
    ramp_sat = (q > {{(PHASE_W-10){1'b0}}, FULL_DUTY}) ? FULL_DUTY : q[7:0];
  endfunction

endpackage

[rtl/core/led_effect_duty_generator_top.sv]
// LED effect duty generator: time keeping, mode state and bit-serial phase reduction.
`include "led_effect_duty_generator_top_macros.svh"

// Each transaction on the input channel is either a millisecond tick or a mode
// change, and yields one transaction on the output with the 8-bit duty and the
// mode in force. An item is taken in the idle state; the restoring divider then
// reduces the time to a phase within the blink or glow period one time bit at a
// time, and the duty is evaluated and registered once the output register is
// free. The next item is taken as soon as that result is registered, even while
// it still waits on the output register. Registers sit on the APB port at byte
// addresses 0x00 to 0x14; a period of zero counts as 65536.
module led_effect_duty_generator_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [led_duty_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         cmd_i,
  input  logic [2:0]                   new_mode_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [7:0]                   duty_o,
  output logic [2:0]                   mode_now_o
);
  import led_duty_pkg::*;

  logic [15:0] blink_period_q, blink_on_time_q, glow_period_q;
  logic [15:0] glow_rise_end_q, glow_fall_end_q;
  logic [31:0] pulse_length_q;

  logic [TIME_BITS-1:0] time_q, time_d, pulse_end_q, pulse_end_d;
  logic [2:0]           mode_q, mode_d;
  state_e               state_q, state_d;
  logic [CNT_W-1:0]     cnt_q;
  logic [TIME_BITS-1:0] dvd_q;
  logic [PHASE_W-1:0]   rem_q, div_q, rem_d, div_d;
  logic [PHASE_W:0]     trial;
  logic [7:0]           duty_q, duty_d;
  logic [2:0]           mode_now_q, mode_fin;
  logic                 out_valid_q;
  logic                 in_fire, slot_free, div_step, finish, cfg_wr;
  logic [2:0]           reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blink_period_q  <= BLINK_PERIOD_RST;
      blink_on_time_q <= BLINK_ON_TIME_RST;
      glow_period_q   <= GLOW_PERIOD_RST;
      glow_rise_end_q <= GLOW_RISE_END_RST;
      glow_fall_end_q <= GLOW_FALL_END_RST;
      pulse_length_q  <= PULSE_LENGTH_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_BLINK_PERIOD:  blink_period_q  <= pwdata[15:0];
        REG_BLINK_ON_TIME: blink_on_time_q <= pwdata[15:0];
        REG_GLOW_PERIOD:   glow_period_q   <= pwdata[15:0];
        REG_GLOW_RISE_END: glow_rise_end_q <= pwdata[15:0];
        REG_GLOW_FALL_END: glow_fall_end_q <= pwdata[15:0];
        REG_PULSE_LENGTH:  pulse_length_q  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_BLINK_PERIOD:  prdata = {16'd0, blink_period_q};
      REG_BLINK_ON_TIME: prdata = {16'd0, blink_on_time_q};
      REG_GLOW_PERIOD:   prdata = {16'd0, glow_period_q};
      REG_GLOW_RISE_END: prdata = {16'd0, glow_rise_end_q};
      REG_GLOW_FALL_END: prdata = {16'd0, glow_fall_end_q};
      REG_PULSE_LENGTH:  prdata = pulse_length_q;
      default:           prdata = 32'd0;
    endcase
  end

  // Effect of the incoming item on time, mode and pulse end.
  always_comb begin
    time_d      = time_q;
    mode_d      = mode_q;
    pulse_end_d = pulse_end_q;
    if (!cmd_i) begin
      time_d = time_q + TIME_BITS'(1);
    end else begin
      mode_d = (new_mode_i > MODE_PULSE) ? MODE_OFF : new_mode_i;
      if (mode_d == MODE_PULSE) begin
        pulse_end_d = time_q + TIME_BITS'(pulse_length_q);
      end
    end
  end

  assign div_d = (mode_d == MODE_BLINK) ? eff_period(blink_period_q)
                                        : eff_period(glow_period_q);

  // One restoring step: bring in the next time bit, subtract if it fits.
  always_comb begin
    trial = {rem_q, dvd_q[TIME_BITS-1]};
    if (trial >= {1'b0, div_q}) begin
      trial = trial - {1'b0, div_q};
    end
    rem_d = trial[PHASE_W-1:0];
  end

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_DIV;
      ST_DIV:  if (cnt_q == '0) state_d = ST_DONE;
      ST_DONE: if (slot_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    div_step   = 1'b0;
    finish     = 1'b0;
    case (state_q)
      ST_IDLE: in_ready_o = 1'b1;
      ST_DIV:  div_step   = 1'b1;
      ST_DONE: finish     = slot_free;
      default: ;
    endcase
  end

  assign in_fire = in_valid_i && in_ready_o;

  // Duty of the current mode at the phase left in the remainder.
  always_comb begin
    mode_fin = mode_q;
    case (mode_q)
      MODE_ON:    duty_d = FULL_DUTY;
      MODE_BLINK: duty_d = (rem_q < {1'b0, blink_on_time_q}) ? FULL_DUTY : 8'd0;
      MODE_GLOW: begin
        if (rem_q < {1'b0, glow_rise_end_q}) begin
          duty_d = ramp_sat(rem_q);
        end else if (rem_q < {1'b0, glow_fall_end_q}) begin
          duty_d = ramp_sat({1'b0, glow_fall_end_q} - rem_q);
        end else begin
          duty_d = 8'd0;
        end
      end
      MODE_PULSE: begin
        duty_d = PULSE_DUTY;
        if (time_q >= pulse_end_q) mode_fin = MODE_OFF;
      end
      default:    duty_d = 8'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      time_q      <= '0;
      mode_q      <= MODE_OFF;
      pulse_end_q <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_fire) begin
        time_q      <= time_d;
        mode_q      <= mode_d;
        pulse_end_q <= pulse_end_d;
        cnt_q       <= CNT_W'(TIME_BITS - 1);
      end else if (div_step) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
      if (finish) begin
        mode_q      <= mode_fin;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      dvd_q <= time_d;
      rem_q <= '0;
      div_q <= div_d;
    end else if (div_step) begin
      dvd_q <= {dvd_q[TIME_BITS-2:0], 1'b0};
      rem_q <= rem_d;
    end
    if (finish) begin
      duty_q     <= duty_d;
      mode_now_q <= mode_fin;
    end
  end

  assign out_valid_o = out_valid_q;
  assign duty_o      = duty_q;
  assign mode_now_o  = mode_now_q;

  `LED_ASSERT(a_mode_legal, mode_q <= MODE_PULSE, "stored mode out of range")
  `LED_ASSERT(a_rem_below_div, (state_q != ST_DIV) || (rem_q < div_q),
              "partial remainder reached the divisor")
  `LED_ASSERT_NEXT(a_accept_starts, in_fire,
                   (state_q == ST_DIV) && (cnt_q == CNT_W'(TIME_BITS - 1)),
                   "accepted item did not start the divider")
  `LED_ASSERT_NEXT(a_finish_valid, finish, out_valid_q && (state_q == ST_IDLE),
                   "finished item produced no result")

endmodule
